/* hdl/ist_pkg.sv */
package ist_pkg;

    // command codes
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_ADD_BACK    = 3'd0;
    localparam t_cmd CMD_ADD_FRONT   = 3'd1;
    localparam t_cmd CMD_REMOVE      = 3'd2;
    localparam t_cmd CMD_SEARCH      = 3'd3;
    localparam t_cmd CMD_CONTAINS    = 3'd4;
    localparam t_cmd CMD_COUNT_USED  = 3'd5;
    localparam t_cmd CMD_COUNT_FREE  = 3'd6;
    localparam t_cmd CMD_HANDLE      = 3'd7;

    // status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NOT_FOUND  = 2'd1;
    localparam t_status ST_FULL       = 2'd2;
    localparam t_status ST_BAD_HANDLE = 2'd3;

    // keys at or above this are ids, below it slot indices
    localparam logic [31:0] ID_BASE = 32'h0100_0000;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // classified command
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
        logic [7:0]  hint;
        logic        big;
    } t_job;

    // back end status
    typedef struct packed {
        logic clearing;
        logic idle;
    } t_bk_stat;

endpackage

/* hdl/ist_front.sv */
module ist_front (
    input  logic               i_valid,
    input  ist_pkg::t_cmd      i_cmd,
    input  logic [31:0]        i_key,
    input  logic [7:0]         i_hint_index,
    input  logic               i_q_full,
    output logic               o_stall,
    output logic               o_push,
    output ist_pkg::t_job      o_job
);

    // hold off while the queue has no room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // tag ids versus direct slot indices
    always_comb begin
        o_job.cmd  = i_cmd;
        o_job.key  = i_key;
        o_job.hint = i_hint_index;
        o_job.big  = (i_key >= ist_pkg::ID_BASE);
    end

endmodule

/* hdl/ist_queue.sv */
module ist_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ist_pkg::t_job      i_job,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output ist_pkg::t_job      o_job
);

    ist_pkg::t_job                 r_mem [ist_pkg::QUEUE_DEPTH];
    logic [ist_pkg::QPW-1:0]       r_wp;
    logic [ist_pkg::QPW-1:0]       r_rp;
    logic [ist_pkg::QCW-1:0]       r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == ist_pkg::QCW'(ist_pkg::QUEUE_DEPTH));
    assign o_job   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == ist_pkg::QPW'(ist_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == ist_pkg::QPW'(ist_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* hdl/ist_back.sv */
module ist_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [8:0]           i_cfg_wr_data,
    input  logic                 i_q_valid,
    input  ist_pkg::t_job        i_job,
    output logic                 o_pop,
    output ist_pkg::t_bk_stat    o_stat,
    output logic                 o_valid,
    input  logic                 i_stall,
    output ist_pkg::t_status     o_status,
    output logic [7:0]           o_slot_index,
    output logic [31:0]          o_value,
    output logic [8:0]           o_count,
    output logic                 o_found
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);
    localparam logic [SW-1:0] RST_EFF = (TABLE_DEPTH < 256) ? SW'(TABLE_DEPTH) : SW'(256);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_DONE
    } t_state;

    // slot memory
    logic [31:0]          r_mem [TABLE_DEPTH];
    logic [31:0]          r_rdata;
    logic                 mem_rd_en;
    logic [IW-1:0]        mem_rd_addr;
    logic                 mem_we;
    logic [IW-1:0]        mem_wr_addr;
    logic [31:0]          mem_wr_data;

    // control
    t_state               r_state, n_state;
    ist_pkg::t_job        r_job, n_job;
    logic [IW-1:0]        r_ptr, n_ptr;
    logic [IW-1:0]        r_rd_addr, n_rd_addr;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_up, n_up;
    logic [SW-1:0]        r_left, n_left;
    logic [SW-1:0]        r_cnt, n_cnt;
    logic [SW-1:0]        r_eff, n_eff;
    logic [SW-1:0]        r_clr_ptr, n_clr_ptr;

    // pending result
    ist_pkg::t_status     r_st, n_st;
    logic [7:0]           r_slot, n_slot;
    logic [31:0]          r_val, n_val;
    logic                 r_fnd, n_fnd;

    // output beat
    logic                 r_o_valid, n_o_valid;
    ist_pkg::t_status     r_o_status, n_o_status;
    logic [7:0]           r_o_slot, n_o_slot;
    logic [31:0]          r_o_value, n_o_value;
    logic [8:0]           r_o_count, n_o_count;
    logic                 r_o_found, n_o_found;

    logic [31:0]          cfg32;
    logic [SW-1:0]        cfg_eff;
    logic                 key_in;
    logic                 hint_in;
    logic                 is_add;
    logic                 is_cnt;
    logic                 want_used;
    logic                 hit;
    logic                 out_free;

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot_index = r_o_slot;
    assign o_value      = r_o_value;
    assign o_count      = r_o_count;
    assign o_found      = r_o_found;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.idle     = (r_state == S_IDLE);

    // next-state logic
    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_ptr     = r_ptr;
        n_up      = r_up;
        n_left    = r_left;
        n_cnt     = r_cnt;
        n_eff     = r_eff;
        n_clr_ptr = r_clr_ptr;
        n_st      = r_st;
        n_slot    = r_slot;
        n_val     = r_val;
        n_fnd     = r_fnd;

        mem_rd_en   = 1'b0;
        mem_rd_addr = r_ptr;
        mem_we      = 1'b0;
        mem_wr_addr = r_rd_addr;
        mem_wr_data = '0;
        o_pop       = 1'b0;

        out_free   = !r_o_valid || !i_stall;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_value  = r_o_value;
        n_o_count  = r_o_count;
        n_o_found  = r_o_found;

        cfg32   = 32'(i_cfg_wr_data);
        cfg_eff = (cfg32 > 32'(TABLE_DEPTH)) ? DEPTH_S : SW'(cfg32);

        key_in  = (i_job.key < 32'(r_eff));
        hint_in = (32'(i_job.hint) < 32'(r_eff));

        is_add    = (r_job.cmd == ist_pkg::CMD_ADD_BACK) ||
                    (r_job.cmd == ist_pkg::CMD_ADD_FRONT);
        is_cnt    = (r_job.cmd == ist_pkg::CMD_COUNT_USED) ||
                    (r_job.cmd == ist_pkg::CMD_COUNT_FREE);
        want_used = (r_job.cmd == ist_pkg::CMD_COUNT_USED);
        hit       = is_add ? (r_rdata == '0) : (r_rdata == r_job.key);

        unique case (r_state)
            // zero slots from the pointer to the top
            S_CLEAR: begin
                if (r_clr_ptr < DEPTH_S) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = r_clr_ptr[IW-1:0];
                    n_clr_ptr   = r_clr_ptr + 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // take a job and pick a path
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_st    = ist_pkg::ST_OK;
                    n_slot  = '0;
                    n_val   = '0;
                    n_fnd   = 1'b0;
                    n_cnt   = '0;
                    n_up    = 1'b0;
                    n_ptr   = IW'(r_eff - 1'b1);
                    n_left  = r_eff;
                    n_state = S_SCAN;
                    unique case (i_job.cmd) inside
                        ist_pkg::CMD_ADD_BACK: begin
                        end
                        ist_pkg::CMD_ADD_FRONT, ist_pkg::CMD_COUNT_USED,
                        ist_pkg::CMD_COUNT_FREE: begin
                            n_up  = 1'b1;
                            n_ptr = '0;
                        end
                        ist_pkg::CMD_REMOVE, ist_pkg::CMD_SEARCH,
                        ist_pkg::CMD_CONTAINS: begin
                            if (!i_job.big) begin
                                if (key_in) begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = i_job.key[IW-1:0];
                                    n_state     = S_CHK;
                                end else begin
                                    n_state = S_DONE;
                                    if (i_job.cmd != ist_pkg::CMD_CONTAINS) begin
                                        n_st = ist_pkg::ST_NOT_FOUND;
                                    end
                                end
                            end
                        end
                        ist_pkg::CMD_HANDLE: begin
                            if (hint_in) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = IW'(32'(i_job.hint));
                                n_state     = S_CHK;
                            end else if (!i_job.big) begin
                                // hint out of range reads as free
                                n_slot  = i_job.hint;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // single-slot access: direct index or handle hint
            S_CHK: begin
                n_state = S_DONE;
                if (r_job.cmd == ist_pkg::CMD_HANDLE) begin
                    if (r_rdata == r_job.key) begin
                        n_slot = r_job.hint;
                        n_val  = r_job.key;
                    end else if (r_job.big) begin
                        n_up    = 1'b0;
                        n_ptr   = IW'(r_eff - 1'b1);
                        n_left  = r_eff;
                        n_state = S_SCAN;
                    end else if (r_rdata >= ist_pkg::ID_BASE) begin
                        n_st = ist_pkg::ST_BAD_HANDLE;
                    end else begin
                        n_slot = r_job.hint;
                        n_val  = r_rdata;
                    end
                end else if (r_rdata != '0) begin
                    n_slot = 8'(r_rd_addr);
                    n_val  = r_rdata;
                    n_fnd  = (r_job.cmd == ist_pkg::CMD_CONTAINS);
                    if (r_job.cmd == ist_pkg::CMD_REMOVE) begin
                        mem_we = 1'b1;
                    end
                end else if (r_job.cmd != ist_pkg::CMD_CONTAINS) begin
                    n_st = ist_pkg::ST_NOT_FOUND;
                end
            end

            // one read per cycle, each read's data checked in the next cycle
            S_SCAN: begin
                if (r_left != '0) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_ptr;
                    n_ptr       = r_up ? r_ptr + 1'b1 : r_ptr - 1'b1;
                    n_left      = r_left - 1'b1;
                end
                if (r_rd_vld) begin
                    if (is_cnt) begin
                        if ((r_rdata != '0) == want_used) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (hit) begin
                        n_slot  = 8'(r_rd_addr);
                        n_val   = r_job.key;
                        n_fnd   = (r_job.cmd == ist_pkg::CMD_CONTAINS);
                        n_state = S_DONE;
                        if (is_add) begin
                            mem_we      = 1'b1;
                            mem_wr_data = r_job.key;
                        end else if (r_job.cmd == ist_pkg::CMD_REMOVE) begin
                            mem_we = 1'b1;
                        end
                    end
                end else if (r_left == '0) begin
                    // ran off the end of the active range
                    n_state = S_DONE;
                    if (is_add) begin
                        n_st = ist_pkg::ST_FULL;
                    end else if (!is_cnt && r_job.cmd != ist_pkg::CMD_CONTAINS) begin
                        n_st = ist_pkg::ST_NOT_FOUND;
                    end
                end
            end

            // hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_st;
                    n_o_slot   = r_slot;
                    n_o_value  = r_val;
                    n_o_count  = 9'(r_cnt);
                    n_o_found  = r_fnd;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // size write: clear everything from the new size up
        if (i_cfg_wr_en) begin
            n_eff     = cfg_eff;
            n_state   = S_CLEAR;
            n_clr_ptr = ((r_state == S_CLEAR) && (r_clr_ptr < cfg_eff)) ? r_clr_ptr : cfg_eff;
        end

        n_rd_vld  = mem_rd_en;
        n_rd_addr = mem_rd_en ? mem_rd_addr : r_rd_addr;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_ptr <= '0;
            r_eff     <= RST_EFF;
            r_rd_vld  <= 1'b0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_ptr <= n_clr_ptr;
            r_eff     <= n_eff;
            r_rd_vld  <= n_rd_vld;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
        r_job      <= n_job;
        r_ptr      <= n_ptr;
        r_up       <= n_up;
        r_rd_addr  <= n_rd_addr;
        r_cnt      <= n_cnt;
        r_st       <= n_st;
        r_slot     <= n_slot;
        r_val      <= n_val;
        r_fnd      <= n_fnd;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_value  <= n_o_value;
        r_o_count  <= n_o_count;
        r_o_found  <= n_o_found;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rdata <= r_mem[mem_rd_addr];
        end
    end

endmodule

/* hdl/id_slot_table_core.sv */
// Id slot table: 32-bit ids held in TABLE_DEPTH slots, zero marks a free slot.
// Input channel (i_valid / o_stall) carries one command beat: i_cmd, i_key,
// i_hint_index. Output channel (o_valid / i_stall) returns exactly one result
// beat per command: o_status, o_slot_index, o_value, o_count, o_found.
// A beat moves on a rising edge with valid high and stall low.
// Commands enter a two-entry queue, so the input side keeps taking beats,
// until the queue is full, while the engine works or a result waits on a
// stalled receiver; a stalled result holds until taken, and the engine then
// waits for the output slot. Direct-index commands and handles read one slot;
// an out-of-range index, or an out-of-range hint with a small key, goes
// straight to the result; adds, id searches and counts scan the active range,
// as does a handle that falls back to an id search. The engine works on one
// command at a time through the slot memory's single read port.
// Reset (i_rst_n low, synchronous) starts a clearing pass over all TABLE_DEPTH
// slots; up to two beats are queued meanwhile, then the input stalls.
// A write of i_cfg_wr_data sets the active size and clears the slots from the
// new size up, one per cycle.
module id_slot_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [7:0]  i_hint_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_index,
    output logic [31:0] o_value,
    output logic [8:0]  o_count,
    output logic        o_found
);

    ist_pkg::t_job      f_job;
    ist_pkg::t_job      q_job;
    ist_pkg::t_bk_stat  bk_stat;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic               q_full;

    // front: accept and classify
    ist_front u_front (
        .i_valid      (i_valid),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_hint_index (i_hint_index),
        .i_q_full     (q_full),
        .o_stall      (o_stall),
        .o_push       (q_push),
        .o_job        (f_job)
    );

    // command queue
    ist_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    // back: table engine and result register
    ist_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_job         (q_job),
        .o_pop         (q_pop),
        .o_stat        (bk_stat),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_value       (o_value),
        .o_count       (o_count),
        .o_found       (o_found)
    );

`ifndef SYNTHESIS
    // engine takes a job only from a non-empty queue and only when idle
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_valid && bk_stat.idle))
        else $error("pop while queue empty or engine busy");

    // the engine leaves idle on every pop, so pops never come back to back
    a_pop_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("back-to-back pops");

    // reset always starts a clearing pass
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> bk_stat.clearing)
        else $error("no clearing pass after reset");
`endif

endmodule

/* bench/testbench.sv */
module testbench;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 300;
    localparam int NUM_PHASES  = 17;

    // one result beat, fields in port order
    typedef struct packed {
        ist_pkg::t_status status;
        logic [7:0]       slot;
        logic [31:0]      value;
        logic [8:0]       count;
        logic             found;
    } t_result;

    // shadow copy of the slot table plus the queue of results still owed
    class t_slot_table_sb;
        logic [31:0]  slots [DEPTH];
        int unsigned  live_size;
        t_result      owed_q[$];
        int           errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            live_size = DEPTH;
            errors = 0;
        endfunction

        // size write: slots from the new size up are wiped
        function void set_size(logic [8:0] v);
            live_size = (v > DEPTH) ? DEPTH : v;
            for (int i = live_size; i < DEPTH; i++) slots[i] = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // ids are scanned top down; small keys name a slot directly
        function bit find_key(logic [31:0] key, output int unsigned at);
            at = 0;
            if (key >= ist_pkg::ID_BASE) begin
                for (int i = int'(live_size) - 1; i >= 0; i--) begin
                    if (slots[i] == key) begin
                        at = i;
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            if (key < live_size && slots[key[7:0]] != '0) begin
                at = key;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // random nonzero entry of the active range, zero if none
        function logic [31:0] pick_stored();
            logic [31:0] ids[$];
            for (int i = 0; i < live_size; i++)
                if (slots[i] != '0) ids.push_back(slots[i]);
            if (ids.size() == 0) return '0;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction

        // accepted command beat: update the table and queue its result
        function void note_cmd(ist_pkg::t_cmd cmd, logic [31:0] key, logic [7:0] hint);
            t_result r;
            int unsigned at;
            int unsigned s;
            logic [31:0] c;
            bit placed;
            r = '0;
            case (cmd) inside
                ist_pkg::CMD_ADD_BACK, ist_pkg::CMD_ADD_FRONT: begin
                    placed = 1'b0;
                    for (int unsigned i = 0; i < live_size; i++) begin
                        s = (cmd == ist_pkg::CMD_ADD_BACK) ? live_size - 1 - i : i;
                        if (slots[s] == '0) begin
                            slots[s] = key;
                            r.slot = 8'(s);
                            r.value = key;
                            placed = 1'b1;
                            break;
                        end
                    end
                    if (!placed) r.status = ist_pkg::ST_FULL;
                end
                ist_pkg::CMD_REMOVE, ist_pkg::CMD_SEARCH: begin
                    if (find_key(key, at)) begin
                        r.slot = 8'(at);
                        r.value = slots[at];
                        if (cmd == ist_pkg::CMD_REMOVE) slots[at] = '0;
                    end else begin
                        r.status = ist_pkg::ST_NOT_FOUND;
                    end
                end
                ist_pkg::CMD_CONTAINS: begin
                    if (find_key(key, at)) begin
                        r.found = 1'b1;
                        r.slot = 8'(at);
                        r.value = slots[at];
                    end
                end
                ist_pkg::CMD_COUNT_USED, ist_pkg::CMD_COUNT_FREE: begin
                    for (int unsigned i = 0; i < live_size; i++)
                        if ((slots[i] != '0) == (cmd == ist_pkg::CMD_COUNT_USED))
                            r.count = 9'(r.count + 1);
                end
                default: begin
                    // handle: hinted slot first, then by id, else raw slot content
                    if (hint < live_size && slots[hint] == key) begin
                        r.slot = hint;
                        r.value = key;
                    end else if (key >= ist_pkg::ID_BASE) begin
                        if (find_key(key, at)) begin
                            r.slot = 8'(at);
                            r.value = key;
                        end else begin
                            r.status = ist_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        c = (hint < live_size) ? slots[hint] : '0;
                        if (c >= ist_pkg::ID_BASE) begin
                            r.status = ist_pkg::ST_BAD_HANDLE;
                        end else begin
                            r.slot = hint;
                            r.value = c;
                        end
                    end
                end
            endcase
            owed_q.push_back(r);
        endfunction

        // accepted result beat against the oldest owed result
        function void check_result(t_result got);
            t_result w;
            if (owed_q.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            w = owed_q.pop_front();
            if (got.status != w.status) begin
                $error("status: expected %0d, got %0d", w.status, got.status);
                errors++;
            end
            if (got.slot != w.slot) begin
                $error("slot_index: expected %0d, got %0d", w.slot, got.slot);
                errors++;
            end
            if (got.value != w.value) begin
                $error("value: expected %h, got %h", w.value, got.value);
                errors++;
            end
            if (got.count != w.count) begin
                $error("count: expected %0d, got %0d", w.count, got.count);
                errors++;
            end
            if (got.found != w.found) begin
                $error("found: expected %0d, got %0d", w.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [8:0]  i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic [31:0] i_key;
    logic [7:0]  i_hint_index;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [7:0]  o_slot_index;
    logic [31:0] o_value;
    logic [8:0]  o_count;
    logic        o_found;

    t_slot_table_sb sb = new();
    int idle_pct  = 20;
    int stall_pct = 20;
    bit hold_req  = 1'b0;
    int cycle_cnt = 0;

    // table size and number of random items per phase
    int phase_size  [NUM_PHASES] = '{256, 0, 1, 2, 8, 4, 16, 3, 64, 256, 6, 32, 255, 10, 5,
                                     128, 7};
    int phase_items [NUM_PHASES] = '{100, 40, 80, 100, 150, 150, 150, 100, 120, 60, 150, 120,
                                     50, 150, 150, 60, 150};

    id_slot_table_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_hint_index (i_hint_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_value      (o_value),
        .o_count      (o_count),
        .o_found      (o_found)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(t_result'({o_status, o_slot_index, o_value, o_count, o_found}));
    end

    // one command beat; returns at the edge that takes it
    task automatic send_cmd(ist_pkg::t_cmd cmd, logic [31:0] key, logic [7:0] hint);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_key        <= key;
        i_hint_index <= hint;
        do @(posedge i_clk); while (o_stall);
        sb.note_cmd(cmd, key, hint);
    endtask

    // size write once every owed result is back
    task automatic write_size(logic [8:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_size(v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] live_hint();
        if (sb.live_size == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, sb.live_size - 1));
    endfunction

    // mix of stored ids, a small id pool, random ids, slot indices, zero and other small keys
    function automatic logic [31:0] any_key();
        int pick;
        logic [31:0] k;
        pick = $urandom_range(0, 99);
        k = sb.pick_stored();
        if (pick < 35 && k != '0) return k;
        if (pick < 60) return ist_pkg::ID_BASE + $urandom_range(0, 23);
        if (pick < 75) return $urandom;
        if (pick < 88) return $urandom_range(0, sb.live_size + 1);
        if (pick < 93) return '0;
        return $urandom & 32'h00FF_FFFF;
    endfunction

    task automatic random_item();
        int pick;
        ist_pkg::t_cmd cmd;
        logic [31:0] key;
        logic [7:0] hint;
        pick = $urandom_range(0, 99);
        key  = any_key();
        hint = 8'($urandom);
        if (pick < 18)      cmd = ist_pkg::CMD_ADD_BACK;
        else if (pick < 34) cmd = ist_pkg::CMD_ADD_FRONT;
        else if (pick < 50) cmd = ist_pkg::CMD_REMOVE;
        else if (pick < 60) cmd = ist_pkg::CMD_SEARCH;
        else if (pick < 70) cmd = ist_pkg::CMD_CONTAINS;
        else if (pick < 75) cmd = ist_pkg::CMD_COUNT_USED;
        else if (pick < 80) cmd = ist_pkg::CMD_COUNT_FREE;
        else                cmd = ist_pkg::CMD_HANDLE;
        // handles: often a hint that really holds the key
        if (cmd == ist_pkg::CMD_HANDLE) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                hint = live_hint();
                key  = sb.slots[hint];
            end else if (pick < 70) begin
                hint = live_hint();
            end
        end
        send_cmd(cmd, key, hint);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = ist_pkg::CMD_ADD_BACK;
        i_key         = '0;
        i_hint_index  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table at full size
        send_cmd(ist_pkg::CMD_COUNT_USED, '0, 8'd0);
        send_cmd(ist_pkg::CMD_COUNT_FREE, '0, 8'd0);
        send_cmd(ist_pkg::CMD_HANDLE, '0, 8'd255);               // free hint, zero key
        send_cmd(ist_pkg::CMD_ADD_BACK, 32'hFFFF_FFFF, 8'd0);
        send_cmd(ist_pkg::CMD_ADD_FRONT, ist_pkg::ID_BASE, 8'd0);
        send_cmd(ist_pkg::CMD_ADD_FRONT, '0, 8'd0);              // zero add leaves slot free
        send_cmd(ist_pkg::CMD_ADD_FRONT, 32'd5, 8'd0);           // small key stored as is
        send_cmd(ist_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 8'd0);
        send_cmd(ist_pkg::CMD_SEARCH, 32'd1, 8'd0);
        send_cmd(ist_pkg::CMD_SEARCH, 32'd2, 8'd0);              // small key on a free slot
        send_cmd(ist_pkg::CMD_CONTAINS, ist_pkg::ID_BASE, 8'd0);
        send_cmd(ist_pkg::CMD_CONTAINS, ist_pkg::ID_BASE - 1, 8'd0); // small key out of range
        send_cmd(ist_pkg::CMD_HANDLE, ist_pkg::ID_BASE, 8'd0);   // hint holds the key
        send_cmd(ist_pkg::CMD_HANDLE, 32'hFFFF_FFFF, 8'd3);      // id away from hint
        send_cmd(ist_pkg::CMD_HANDLE, 32'h1234_5678, 8'd9);      // absent id
        send_cmd(ist_pkg::CMD_HANDLE, 32'd7, 8'd0);              // hint holds an id
        send_cmd(ist_pkg::CMD_HANDLE, 32'd7, 8'd1);              // hint holds a small value
        send_cmd(ist_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(ist_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(ist_pkg::CMD_REMOVE, 32'd1, 8'd0);
        send_cmd(ist_pkg::CMD_SEARCH, '0, 8'd0);
        send_cmd(ist_pkg::CMD_COUNT_USED, '0, 8'd0);
        repeat (60) random_item();

        // random phases over a range of table sizes
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_size(9'(phase_size[p]));
            idle_pct  = (p == 5) ? 0 : 20;
            stall_pct = (p == 5) ? 0 : 20;
            if (p == 4) hold_req = 1'b1;
            repeat (phase_items[p]) random_item();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ist_pkg.sv
hdl/ist_front.sv
hdl/ist_queue.sv
hdl/ist_back.sv
hdl/id_slot_table_core.sv
bench/testbench.sv
